FILE: hw/rtl/modbus_pdu_parser_defines.svh
// assertion macros for the modbus pdu parser
// no dependencies; expects clk and rst in the scope of each use
`ifndef MODBUS_PDU_PARSER_DEFINES_SVH
`define MODBUS_PDU_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mpp_pkg.sv
// shared types, codes and helper functions of the modbus pdu parser
// no dependencies
package mpp_pkg;

  // header bytes kept per pdu and saturation point of the byte position
  localparam int unsigned HDR_KEEP = 11;
  localparam logic [8:0] IDX_MAX = 9'd511;

  // default depth of the result queue
  localparam int unsigned MPP_RES_DEPTH = 4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_UNSUPP  = 2'd2;

  // function codes
  localparam logic [7:0] FC_RD_COILS  = 8'd1;
  localparam logic [7:0] FC_RD_DISC   = 8'd2;
  localparam logic [7:0] FC_RD_HOLD   = 8'd3;
  localparam logic [7:0] FC_RD_INPUT  = 8'd4;
  localparam logic [7:0] FC_WR_COIL   = 8'd5;
  localparam logic [7:0] FC_WR_REG    = 8'd6;
  localparam logic [7:0] FC_WR_COILS  = 8'd15;
  localparam logic [7:0] FC_WR_REGS   = 8'd16;
  localparam logic [7:0] FC_MASK_WR   = 8'd22;
  localparam logic [7:0] FC_RDWR_REGS = 8'd23;

  // pdu format kinds
  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_RDREQ  = 4'd1;
  localparam logic [3:0] K_SINGLE = 4'd2;
  localparam logic [3:0] K_WRREQ  = 4'd3;
  localparam logic [3:0] K_WRRSP  = 4'd4;
  localparam logic [3:0] K_MASK   = 4'd5;
  localparam logic [3:0] K_WRRD   = 4'd6;
  localparam logic [3:0] K_RDRSP  = 4'd7;
  localparam logic [3:0] K_EXC    = 4'd8;

  // one result item
  typedef struct packed {
    logic        is_summary;
    logic [1:0]  status;
    logic [7:0]  func_code;
    logic [7:0]  except_code;
    logic [15:0] address_a;
    logic [15:0] value_a;
    logic [15:0] address_b;
    logic [15:0] value_b;
    logic [7:0]  data_len;
    logic [8:0]  frame_len;
    logic [7:0]  payload_byte;
    logic        last_of_run;
  } result_t;

  // results produced by one item, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // format kind from function code and mode
  function automatic logic [3:0] classify(input logic [7:0] fc, input logic mode);
    logic [3:0] k;
    k = K_NONE;
    if (mode && fc[7]) begin
      k = K_EXC;
    end else begin
      case (fc) inside
        FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT: k = mode ? K_RDRSP : K_RDREQ;
        FC_WR_COIL, FC_WR_REG:                            k = K_SINGLE;
        FC_WR_COILS, FC_WR_REGS:                          k = mode ? K_WRRSP : K_WRREQ;
        FC_MASK_WR:                                       k = K_MASK;
        FC_RDWR_REGS:                                     k = mode ? K_RDRSP : K_WRRD;
        default:                                          k = K_NONE;
      endcase
    end
    return k;
  endfunction

  // minimum pdu length of a format
  function automatic logic [3:0] min_len(input logic [3:0] k);
    logic [3:0] m;
    case (k) inside
      K_EXC:          m = 4'd2;
      K_RDRSP:        m = 4'd3;
      K_WRREQ, K_MASK: m = 4'd7;
      K_WRRD:         m = 4'd11;
      default:        m = 4'd5;
    endcase
    return m;
  endfunction

  // offset of the first payload byte, zero when the format has none
  function automatic logic [3:0] payload_start(input logic [3:0] k);
    logic [3:0] s;
    case (k)
      K_RDRSP: s = 4'd2;
      K_WRREQ: s = 4'd6;
      K_WRRD:  s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/mpp_decode.sv
// combinational decode of one pdu byte into payload and summary results
// depends on mpp_pkg
module mpp_decode
  import mpp_pkg::*;
(
  input  logic [7:0] hdr [HDR_KEEP],
  input  logic [8:0] byte_index,
  input  logic [7:0] pdu_byte,
  input  logic       end_of_pdu,
  input  logic       response_mode,
  output push_t      push
);

  always_comb begin
    logic [7:0]  hdr_w [HDR_KEEP];
    logic [3:0]  kind;
    logic [3:0]  hs;
    logic [7:0]  dlen;
    logic [8:0]  rel;
    logic        pay;
    logic [9:0]  len;
    result_t     pres;
    result_t     sres;

    // header as it stands with this byte written
    for (int i = 0; i < HDR_KEEP; i++) begin
      hdr_w[i] = ((byte_index < 9'(HDR_KEEP)) && (byte_index[3:0] == 4'(i))) ?
                 pdu_byte : hdr[i];
    end

    kind = classify(hdr_w[0], response_mode);
    hs   = payload_start(kind);

    // declared data length byte of the format
    case (kind)
      K_RDRSP: dlen = hdr_w[1];
      K_WRREQ: dlen = hdr_w[5];
      K_WRRD:  dlen = hdr_w[9];
      default: dlen = 8'd0;
    endcase

    // payload window check
    rel = byte_index - {5'd0, hs};
    pay = (hs != 4'd0) && (byte_index >= {5'd0, hs}) && (rel < {1'b0, dlen});

    pres              = '0;
    pres.func_code    = hdr_w[0];
    pres.payload_byte = pdu_byte;
    pres.last_of_run  = !end_of_pdu;

    // summary fields per format
    len             = {1'b0, byte_index} + 10'd1;
    sres            = '0;
    sres.is_summary = 1'b1;
    sres.func_code  = hdr_w[0];
    sres.last_of_run = 1'b1;
    if (kind == K_NONE) begin
      sres.status = ST_UNSUPP;
    end else if (len < {6'd0, min_len(kind)}) begin
      sres.status = ST_SHORT;
    end else begin
      case (kind)
        K_EXC: begin
          sres.except_code = hdr_w[1];
          sres.frame_len   = 9'd2;
        end
        K_RDRSP: begin
          sres.data_len  = hdr_w[1];
          sres.frame_len = 9'd2 + {1'b0, hdr_w[1]};
        end
        K_WRREQ: begin
          sres.address_a = {hdr_w[1], hdr_w[2]};
          sres.value_a   = {hdr_w[3], hdr_w[4]};
          sres.data_len  = hdr_w[5];
          sres.frame_len = 9'd6 + {1'b0, hdr_w[5]};
        end
        K_MASK: begin
          sres.address_a = {hdr_w[1], hdr_w[2]};
          sres.value_a   = {hdr_w[3], hdr_w[4]};
          sres.value_b   = {hdr_w[5], hdr_w[6]};
          sres.frame_len = 9'd7;
        end
        K_WRRD: begin
          sres.address_a = {hdr_w[1], hdr_w[2]};
          sres.value_a   = {hdr_w[3], hdr_w[4]};
          sres.address_b = {hdr_w[5], hdr_w[6]};
          sres.value_b   = {hdr_w[7], hdr_w[8]};
          sres.data_len  = hdr_w[9];
          sres.frame_len = 9'd10 + {1'b0, hdr_w[9]};
        end
        default: begin
          sres.address_a = {hdr_w[1], hdr_w[2]};
          sres.value_a   = {hdr_w[3], hdr_w[4]};
          sres.frame_len = 9'd5;
        end
      endcase
    end

    // order: payload first, then summary
    push = '0;
    if (pay) begin
      push.res0  = pres;
      push.res1  = sres;
      push.count = end_of_pdu ? 2'd2 : 2'd1;
    end else begin
      push.res0  = sres;
      push.res1  = sres;
      push.count = end_of_pdu ? 2'd1 : 2'd0;
    end
  end

endmodule

FILE: hw/rtl/mpp_res_fifo.sv
// small result queue taking up to two items per cycle and giving one per cycle unless out_stall is high
// depends on mpp_pkg
module mpp_res_fifo
  import mpp_pkg::*;
#(
  parameter int unsigned DEPTH = MPP_RES_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  push_t                        push,
  output logic                         room2,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output result_t                      head
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  result_t       entries [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr1;
  logic [PW-1:0] wr_ptr2;
  logic [PW-1:0] rd_ptr_next;
  logic [CW-1:0] count_next;
  logic          pop;

  // pointer steps with explicit wrap
  assign wr_ptr1     = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
  assign wr_ptr2     = (wr_ptr1 == LAST_PTR) ? '0 : wr_ptr1 + PW'(1);
  assign rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign head       = entries[rd_ptr];
  assign room2      = (count <= CW'(DEPTH - 2));
  assign count_next = count + CW'(push.count) - CW'(pop);

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr1] <= push.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= wr_ptr;
      endcase
    end
  end

endmodule

FILE: hw/rtl/modbus_pdu_parser.sv
// Modbus PDU parser, byte-serial.
// Input channel: pdu_byte with end_of_pdu on the final byte, in_valid/in_stall.
// An item is taken when in_valid is high and in_stall is low.
// Output channel: one result item per transfer, out_valid/out_stall; each input
// byte gives no result, one payload result, a summary result, or a payload
// result followed by the summary when the final byte is also payload.
// last_of_run marks the final result caused by an input byte.
// Config: response_mode written through cfg_valid/cfg_ready (ready is always
// high); write it only while no PDU byte is in flight.
// Timing: a taken byte waits in the input register, is decoded, and its results
// pass through the result queue to the outputs. Throughput is one byte per cycle
// while in_stall is low; a final payload byte gives two results, which the
// single-result output port drains from the result queue (depth RES_DEPTH). The
// input register holds while the queue has fewer than two free entries.
// Reset (rst, synchronous) clears the byte position, kept header bytes, mode
// and the queue. When the receiver stalls, results wait in the queue and,
// once it is nearly full, in_stall rises.
// depends on mpp_pkg, mpp_decode, mpp_res_fifo, modbus_pdu_parser_defines.svh
`include "modbus_pdu_parser_defines.svh"

module modbus_pdu_parser
  import mpp_pkg::*;
#(
  parameter int unsigned RES_DEPTH = MPP_RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        response_mode,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pdu_byte,
  input  logic        end_of_pdu,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_summary,
  output logic [1:0]  status,
  output logic [7:0]  func_code,
  output logic [7:0]  except_code,
  output logic [15:0] address_a,
  output logic [15:0] value_a,
  output logic [15:0] address_b,
  output logic [15:0] value_b,
  output logic [7:0]  data_len,
  output logic [8:0]  frame_len,
  output logic [7:0]  payload_byte,
  output logic        last_of_run
);

  logic        resp_mode;
  logic        stage_valid;
  logic        stage_valid_next;
  logic [7:0]  stage_byte;
  logic        stage_end;
  logic [8:0]  byte_index;
  logic [7:0]  hdr [HDR_KEEP];
  logic        accept;
  logic        fire;
  logic        room2;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;
  push_t       push;
  push_t       push_q;
  result_t     head;

  assign cfg_ready = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      resp_mode <= response_mode;
    end
  end

  // input register handshake
  assign fire             = stage_valid && room2;
  assign in_stall         = stage_valid && !fire;
  assign accept           = in_valid && !in_stall;
  assign stage_valid_next = accept ? 1'b1 : (fire ? 1'b0 : stage_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= pdu_byte;
      stage_end  <= end_of_pdu;
    end
  end

  // per-pdu state: byte position and kept header bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      for (int i = 0; i < HDR_KEEP; i++) begin
        hdr[i] <= '0;
      end
    end else if (fire) begin
      if (stage_end) begin
        byte_index <= '0;
        for (int i = 0; i < HDR_KEEP; i++) begin
          hdr[i] <= '0;
        end
      end else begin
        if (byte_index < 9'(HDR_KEEP)) begin
          hdr[byte_index[3:0]] <= stage_byte;
        end
        byte_index <= (byte_index < IDX_MAX) ? byte_index + 9'd1 : IDX_MAX;
      end
    end
  end

  // decode of the held byte
  mpp_decode u_decode (
    .hdr           (hdr),
    .byte_index    (byte_index),
    .pdu_byte      (stage_byte),
    .end_of_pdu    (stage_end),
    .response_mode (resp_mode),
    .push          (push)
  );

  // results go to the queue only when the byte is consumed
  always_comb begin
    push_q = push;
    if (!fire) begin
      push_q.count = 2'd0;
    end
  end

  mpp_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_q),
    .room2     (room2),
    .count     (res_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields
  assign is_summary   = head.is_summary;
  assign status       = head.status;
  assign func_code    = head.func_code;
  assign except_code  = head.except_code;
  assign address_a    = head.address_a;
  assign value_a      = head.value_a;
  assign address_b    = head.address_b;
  assign value_b      = head.value_b;
  assign data_len     = head.data_len;
  assign frame_len    = head.frame_len;
  assign payload_byte = head.payload_byte;
  assign last_of_run  = head.last_of_run;

  // checks
  `MPP_ASSERT_NOW(a_queue_bound, 1'b1, res_count <= ($clog2(RES_DEPTH+1))'(RES_DEPTH), "result queue overflow")
  `MPP_ASSERT_NEXT(a_end_clears, fire && stage_end, byte_index == 9'd0 && hdr[0] == 8'd0, "pdu state not cleared after final byte")
  `MPP_ASSERT_NOW(a_summary_last, out_valid && is_summary, last_of_run, "summary result not marked last")

endmodule

FILE: tb/sv/modbus_pdu_parser_test.sv
// self-checking testbench for modbus_pdu_parser: byte stimulus, mode writes, result checks
// depends on mpp_pkg and the modbus_pdu_parser rtl
`timescale 1ns / 100ps

module modbus_pdu_parser_test;
  import mpp_pkg::*;

  // codes with no format of their own, and the exception flag bit
  localparam logic [7:0] FC_UNDEF_7  = 8'd7;
  localparam logic [7:0] FC_UNDEF_17 = 8'd17;
  localparam logic [7:0] FC_NULL     = 8'd0;
  localparam logic [7:0] EXC_FLAG    = 8'h80;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;

  // expected results of the parser, kept with a private copy of its state
  class pdu_scoreboard;
    result_t     pending_results[$];
    logic        mode;
    logic [8:0]  pos;
    logic [7:0]  hdr [HDR_KEEP];
    int unsigned errors;

    function new();
      mode = 1'b0;
      errors = 0;
      clear_pdu();
    endfunction

    function void clear_pdu();
      pos = '0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // format of the pdu from its function code and the current mode
    function logic [3:0] kind_of(logic [7:0] fc);
      if (mode && fc[7]) return K_EXC;
      case (fc) inside
        FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT: return mode ? K_RDRSP : K_RDREQ;
        FC_WR_COIL, FC_WR_REG: return K_SINGLE;
        FC_WR_COILS, FC_WR_REGS: return mode ? K_WRRSP : K_WRREQ;
        FC_MASK_WR: return K_MASK;
        FC_RDWR_REGS: return mode ? K_RDRSP : K_WRRD;
        default: return K_NONE;
      endcase
    endfunction

    function int shortest(logic [3:0] kind);
      case (kind) inside
        K_EXC: return 2;
        K_RDRSP: return 3;
        K_WRREQ, K_MASK: return 7;
        K_WRRD: return 11;
        default: return 5;
      endcase
    endfunction

    // position of the first data byte, zero when the format carries none
    function int data_offset(logic [3:0] kind);
      case (kind)
        K_RDRSP: return 2;
        K_WRREQ: return 6;
        K_WRRD: return 10;
        default: return 0;
      endcase
    endfunction

    function logic [15:0] word_at(int i);
      return {hdr[i], hdr[i+1]};
    endfunction

    // work out the results of one accepted byte
    function void note_byte(logic [7:0] b, logic eop);
      logic [3:0] kind;
      int         first_data;
      int         len;
      result_t    r;
      if (pos < HDR_KEEP) hdr[pos] = b;
      kind = kind_of(hdr[0]);
      first_data = data_offset(kind);
      // payload byte inside the declared data length
      if (first_data != 0 && int'(pos) >= first_data &&
          int'(pos) - first_data < int'(hdr[first_data-1])) begin
        r = '0;
        r.func_code = hdr[0];
        r.payload_byte = b;
        r.last_of_run = !eop;
        pending_results.push_back(r);
      end
      if (!eop) begin
        pos = (pos < IDX_MAX) ? pos + 9'd1 : IDX_MAX;
        return;
      end
      // summary on the final byte
      len = int'(pos) + 1;
      r = '0;
      r.is_summary = 1'b1;
      r.func_code = hdr[0];
      r.last_of_run = 1'b1;
      if (kind == K_NONE) begin
        r.status = ST_UNSUPP;
      end else if (len < shortest(kind)) begin
        r.status = ST_SHORT;
      end else begin
        r.status = ST_OK;
        case (kind)
          K_EXC: begin
            r.except_code = hdr[1];
            r.frame_len = 9'd2;
          end
          K_RDRSP: begin
            r.data_len = hdr[1];
            r.frame_len = 9'd2 + 9'(hdr[1]);
          end
          K_WRREQ: begin
            r.address_a = word_at(1);
            r.value_a = word_at(3);
            r.data_len = hdr[5];
            r.frame_len = 9'd6 + 9'(hdr[5]);
          end
          K_MASK: begin
            r.address_a = word_at(1);
            r.value_a = word_at(3);
            r.value_b = word_at(5);
            r.frame_len = 9'd7;
          end
          K_WRRD: begin
            r.address_a = word_at(1);
            r.value_a = word_at(3);
            r.address_b = word_at(5);
            r.value_b = word_at(7);
            r.data_len = hdr[9];
            r.frame_len = 9'd10 + 9'(hdr[9]);
          end
          default: begin
            r.address_a = word_at(1);
            r.value_a = word_at(3);
            r.frame_len = 9'd5;
          end
        endcase
      end
      pending_results.push_back(r);
      clear_pdu();
    endfunction

    function string show(result_t r);
      return $sformatf({"sum=%0d st=%0d fc=%02h exc=%02h aa=%04h va=%04h ab=%04h vb=%04h",
                        " dlen=%0d flen=%0d pay=%02h last=%0d"},
                       r.is_summary, r.status, r.func_code, r.except_code, r.address_a,
                       r.value_a, r.address_b, r.value_b, r.data_len, r.frame_len,
                       r.payload_byte, r.last_of_run);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        response_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pdu_byte = '0;
  logic        end_of_pdu = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_summary;
  logic [1:0]  status;
  logic [7:0]  func_code;
  logic [7:0]  except_code;
  logic [15:0] address_a;
  logic [15:0] value_a;
  logic [15:0] address_b;
  logic [15:0] value_b;
  logic [7:0]  data_len;
  logic [8:0]  frame_len;
  logic [7:0]  payload_byte;
  logic        last_of_run;
  result_t     out_item;

  pdu_scoreboard sb = new();

  // sender and receiver pacing
  int         burst_left = 0;
  bit         steady = 1'b0;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         cyc = 0;
  int         idle_cycles = 0;
  logic [7:0] pdu_q[$];
  bit         long_pdu;

  modbus_pdu_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .response_mode(response_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pdu_byte     (pdu_byte),
    .end_of_pdu   (end_of_pdu),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_summary   (is_summary),
    .status       (status),
    .func_code    (func_code),
    .except_code  (except_code),
    .address_a    (address_a),
    .value_a      (value_a),
    .address_b    (address_b),
    .value_b      (value_b),
    .data_len     (data_len),
    .frame_len    (frame_len),
    .payload_byte (payload_byte),
    .last_of_run  (last_of_run)
  );

  assign out_item = {is_summary, status, func_code, except_code, address_a, value_a,
                     address_b, value_b, data_len, frame_len, payload_byte, last_of_run};

  always #2 clk = ~clk;

  // receiver: check accepted results, stall in stretches of varying density
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      cyc <= cyc + 1;
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= cyc[2];
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // send one byte, with a random gap at the start of each burst unless pacing is steady
  task automatic send_item(input logic [7:0] b, input logic eop);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pdu_byte <= b;
    end_of_pdu <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, eop);
    burst_left--;
  endtask

  task automatic send_pdu();
    foreach (pdu_q[i]) send_item(pdu_q[i], i == pdu_q.size() - 1);
  endtask

  // hold the sender until every expected result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_mode(input logic v);
    drain();
    cfg_valid <= 1'b1;
    response_mode <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0: return FC_RD_COILS;
      1: return FC_RD_DISC;
      2: return FC_RD_HOLD;
      3: return FC_RD_INPUT;
      4: return FC_WR_COIL;
      5: return FC_WR_REG;
      6: return FC_WR_COILS;
      7: return FC_WR_REGS;
      8: return FC_MASK_WR;
      default: return FC_RDWR_REGS;
    endcase
  endfunction

  // build one random pdu: mostly well-formed, some cut short, some noise, rarely long
  function automatic void fill_pdu(input logic m, input bit force_long);
    logic [7:0] fc;
    int         sel;
    int         dlen;
    int         fixed;
    bit         has_data;
    bit         rd_like;
    int         cut;
    pdu_q.delete();
    sel = $urandom_range(0, 199);
    long_pdu = force_long || sel >= 198;
    if (long_pdu) begin
      repeat ($urandom_range(512, 530)) pdu_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (sel >= 170) begin
      repeat ($urandom_range(1, 12)) pdu_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
    if (m && $urandom_range(0, 7) == 0) begin
      pdu_q.push_back(EXC_FLAG | 8'($urandom_range(0, 127)));
      pdu_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      fc = pick_code();
      pdu_q.push_back(fc);
      rd_like = fc inside {FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT, FC_RDWR_REGS};
      if (fc == FC_MASK_WR) begin
        fixed = 6;
        has_data = 1'b0;
      end else if (m) begin
        fixed = rd_like ? 0 : 4;
        has_data = rd_like;
      end else begin
        fixed = (fc == FC_RDWR_REGS) ? 8 : 4;
        has_data = fc inside {FC_WR_COILS, FC_WR_REGS, FC_RDWR_REGS};
      end
      repeat (fixed) pdu_q.push_back(8'($urandom_range(0, 255)));
      if (has_data) begin
        pdu_q.push_back(8'(dlen));
        repeat (dlen) pdu_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // trailing bytes past the declared data
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) pdu_q.push_back(8'($urandom_range(0, 255)));
    end
    // cut short
    if (sel >= 140 && pdu_q.size() > 1) begin
      cut = $urandom_range(1, pdu_q.size() - 1);
      while (pdu_q.size() > cut) void'(pdu_q.pop_back());
    end
  endfunction

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, unsupported codes, short pdus, payload on the final byte
    write_mode(1'b0);
    pdu_q = '{8'hFF};
    send_pdu();
    pdu_q = '{FC_UNDEF_7};
    send_pdu();
    pdu_q = '{FC_NULL, FC_UNDEF_17};
    send_pdu();
    pdu_q = '{FC_UNDEF_17, 8'h00, 8'h01, 8'h00, 8'h02};
    send_pdu();
    pdu_q = '{FC_RD_HOLD, 8'h00, 8'hFF};
    send_pdu();
    pdu_q = '{FC_WR_REGS, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h01, 8'hA5};
    send_pdu();
    // mode switched in the middle of a pdu
    send_item(FC_RD_INPUT, 1'b0);
    send_item(8'h12, 1'b0);
    write_mode(1'b1);
    send_item(8'h55, 1'b1);
    // exception response, complete and short
    pdu_q = '{EXC_FLAG | FC_RD_HOLD, 8'h02};
    send_pdu();
    pdu_q = '{EXC_FLAG};
    send_pdu();

    // random phases, each under its own mode, with a full drain between them
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 2) write_mode(phase[0]);
      else write_mode(1'($urandom_range(0, 1)));
      steady = (phase == 3 || phase == 6);
      sent = 0;
      if (phase == 2) begin
        fill_pdu(sb.mode, 1'b1);
        send_pdu();
        sent += pdu_q.size();
      end
      while (sent < PHASE_ITEMS) begin
        fill_pdu(sb.mode, 1'b0);
        send_pdu();
        sent += pdu_q.size();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: modbus_pdu_parser.f
+incdir+hw/rtl
hw/rtl/mpp_pkg.sv
hw/rtl/mpp_decode.sv
hw/rtl/mpp_res_fifo.sv
hw/rtl/modbus_pdu_parser.sv
tb/sv/modbus_pdu_parser_test.sv
